// ===== hdl/ipv_pkg.sv =====
`timescale 1ns / 1ps
package ipv_pkg;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CASE_BIT  = 8'h20;
	localparam logic [11:0] OCTET_MAX = 12'h0FF;
	localparam logic [8:0] OCTET_SAT = 9'h100;
	localparam logic [20:0] GROUP_MAX = 21'h00FFFF;
	localparam logic [16:0] GROUP_SAT = 17'h10000;

	// classification codes on the family output
	localparam logic [1:0] FAM_NONE = 2'd0;
	localparam logic [1:0] FAM_V4   = 2'd1;
	localparam logic [1:0] FAM_V6   = 2'd2;

	// dotted decimal tracker
	typedef struct packed {
		logic [1:0] length_seen;
		logic [2:0] dot_count;
		logic [7:0] prev_char;
		logic [7:0] prev_prev_char;
		logic [8:0] octet_value;
		logic       ok;
	} v4_trk_t;

	// colon and hex group tracker
	typedef struct packed {
		logic [3:0]  colon_count;
		logic [1:0]  double_colon_count;
		logic [16:0] hex_group_value;
		logic        prefix_hex_ok;
		logic        segment_hex_ok;
	} hex_trk_t;

	function automatic v4_trk_t v4_clear();
		v4_trk_t r;
		r.length_seen    = '0;
		r.dot_count      = '0;
		r.prev_char      = '0;
		r.prev_prev_char = '0;
		r.octet_value    = '0;
		r.ok             = 1'b1;
		return r;
	endfunction

	function automatic v4_trk_t v4_feed(v4_trk_t t, logic [7:0] c);
		v4_trk_t r;
		logic [11:0] acc;
		r = t;
		acc = {3'b000, t.octet_value} * 12'd10 + {8'h00, c[3:0]};
		if (t.length_seen == 2'd0 && c == CH_DOT) begin
			r.ok = 1'b0;
		end
		if (t.length_seen != 2'd0 && t.prev_char == CH_DOT && c == CH_DOT) begin
			r.ok = 1'b0;
		end
		if (t.length_seen[1] && t.prev_prev_char == CH_DOT && t.prev_char == CH_ZERO
				&& c != CH_DOT) begin
			r.ok = 1'b0;
		end
		if (c == CH_DOT) begin
			if (t.dot_count != 3'd7) begin
				r.dot_count = t.dot_count + 3'd1;
			end
			r.octet_value = '0;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			if (acc > OCTET_MAX) begin
				r.ok = 1'b0;
				r.octet_value = OCTET_SAT;
			end else begin
				r.octet_value = acc[8:0];
			end
		end else begin
			r.ok = 1'b0;
		end
		r.prev_prev_char = t.prev_char;
		r.prev_char = c;
		if (t.length_seen != 2'd3) begin
			r.length_seen = t.length_seen + 2'd1;
		end
		return r;
	endfunction

	function automatic logic v4_final(v4_trk_t t);
		return t.ok && t.length_seen[1] && t.prev_char != CH_DOT && t.dot_count == 3'd3;
	endfunction

	function automatic hex_trk_t hex_clear();
		hex_trk_t r;
		r.colon_count        = '0;
		r.double_colon_count = '0;
		r.hex_group_value    = '0;
		r.prefix_hex_ok      = 1'b1;
		r.segment_hex_ok     = 1'b1;
		return r;
	endfunction

endpackage

// ===== hdl/ip_address_text_validator_top.sv =====
`timescale 1ns / 1ps
// address text validator: takes one character per beat, with last_char on the final one,
// and returns one beat per string that classifies it as ipv4 (family 1), ipv6 (family 2)
// or invalid (family 0); ipv4_ok and ipv6_ok report each rule set on its own, and ipv4
// wins when both pass. a new character is taken every cycle unless in_stall holds it off; the
// character sits in an input register while the tracker flags and counters are updated, and
// the classification lands in an output register. while a result waits under out_stall
// the block still takes characters of the next string and only holds off once a second final
// character is ready to finish.
module ip_address_text_validator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] character,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] family,
	output logic       ipv4_ok,
	output logic       ipv6_ok
);
	import ipv_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// output register
	logic       out_valid_q;
	logic [1:0] family_q;
	logic       ipv4_ok_q;
	logic       ipv6_ok_q;

	logic     adv;
	logic     done;
	logic     is_colon;
	logic     prev_colon;
	v4_trk_t  whole_cur;
	v4_trk_t  whole_eff;
	v4_trk_t  tail_cur;
	v4_trk_t  tail_eff;
	hex_trk_t hex_eff;
	logic     v4_pass;
	logic     v6_pass;

	// a plain character always moves on; a final one needs the output slot free
	assign adv  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign done = last_s1;
	assign in_stall = valid_s1 && !adv;

	assign is_colon   = char_s1 == CH_COLON;
	// only a colon leaves the tail tracker empty once the string has started
	assign prev_colon = whole_cur.length_seen != 2'd0 && tail_cur.length_seen == 2'd0;

	// whole string, read as dotted decimal
	ipv_trk u_whole (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.ch      (char_s1),
		.restart (1'b0),
		.done    (done),
		.cur     (whole_cur),
		.eff     (whole_eff)
	);

	// text after the latest colon, for an embedded ipv4 tail
	ipv_trk u_tail (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.ch      (char_s1),
		.restart (is_colon),
		.done    (done),
		.cur     (tail_cur),
		.eff     (tail_eff)
	);

	// colon counts and hex groups
	ipv_hex u_hex (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.ch         (char_s1),
		.prev_colon (prev_colon),
		.done       (done),
		.eff        (hex_eff)
	);

	// classification of the string as it stands after this character
	always_comb begin
		v4_pass = v4_final(whole_eff);
		v6_pass = whole_eff.length_seen[1];
		if (hex_eff.double_colon_count > 2'd1) begin
			v6_pass = 1'b0;
		end
		if (hex_eff.double_colon_count == 2'd1 && hex_eff.colon_count > 4'd7) begin
			v6_pass = 1'b0;
		end
		if (hex_eff.double_colon_count == 2'd0 && hex_eff.colon_count != 4'd7) begin
			v6_pass = 1'b0;
		end
		if (whole_eff.dot_count != 3'd0 && whole_eff.dot_count != 3'd3) begin
			v6_pass = 1'b0;
		end
		if (whole_eff.dot_count == 3'd0) begin
			v6_pass = v6_pass && hex_eff.prefix_hex_ok && hex_eff.segment_hex_ok;
		end else begin
			v6_pass = v6_pass && hex_eff.prefix_hex_ok && v4_final(tail_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			ipv4_ok_q <= v4_pass;
			ipv6_ok_q <= v6_pass;
			if (v4_pass) begin
				family_q <= FAM_V4;
			end else if (v6_pass) begin
				family_q <= FAM_V6;
			end else begin
				family_q <= FAM_NONE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign family    = family_q;
	assign ipv4_ok   = ipv4_ok_q;
	assign ipv6_ok   = ipv6_ok_q;

`ifndef ASSERT_OFF
	a_fam_v4 : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && family_q == FAM_V4) |-> ipv4_ok_q)
		else $error("family ipv4 without ipv4_ok");
	a_fam_v6 : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && family_q == FAM_V6) |-> (ipv6_ok_q && !ipv4_ok_q))
		else $error("family ipv6 inconsistent with flags");
	a_fam_none : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && family_q == FAM_NONE) |-> (!ipv4_ok_q && !ipv6_ok_q))
		else $error("invalid family with a passing flag");
	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q))
		else $error("input held off without a final character blocked");
`endif

endmodule

// ===== hdl/ipv_trk.sv =====
`timescale 1ns / 1ps
module ipv_trk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       ch,
	input  logic             restart,
	input  logic             done,
	output ipv_pkg::v4_trk_t cur,
	output ipv_pkg::v4_trk_t eff
);
	import ipv_pkg::*;

	v4_trk_t trk_q;

	// restart drops the history instead of taking the character
	assign cur = trk_q;
	assign eff = restart ? v4_clear() : v4_feed(trk_q, ch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= v4_clear();
		end else if (step) begin
			trk_q <= done ? v4_clear() : eff;
		end
	end

endmodule

// ===== hdl/ipv_hex.sv =====
`timescale 1ns / 1ps
module ipv_hex (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        ch,
	input  logic              prev_colon,
	input  logic              done,
	output ipv_pkg::hex_trk_t eff
);
	import ipv_pkg::*;

	hex_trk_t   hex_q;
	logic [7:0] up;
	logic [3:0] dig;
	logic       is_hex;
	logic [20:0] acc;

	always_comb begin
		up = ch;
		if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
			up = ch - CASE_BIT;
		end
		is_hex = 1'b1;
		dig = '0;
		if (up >= CH_ZERO && up <= CH_NINE) begin
			dig = up[3:0];
		end else if (up >= CH_UP_A && up <= CH_UP_F) begin
			dig = up[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
		acc = {hex_q.hex_group_value, 4'h0} + {17'h00000, dig};

		eff = hex_q;
		if (ch == CH_COLON) begin
			if (prev_colon && hex_q.double_colon_count != 2'd3) begin
				eff.double_colon_count = hex_q.double_colon_count + 2'd1;
			end
			if (hex_q.colon_count != 4'd15) begin
				eff.colon_count = hex_q.colon_count + 4'd1;
			end
			eff.prefix_hex_ok   = hex_q.prefix_hex_ok && hex_q.segment_hex_ok;
			eff.segment_hex_ok  = 1'b1;
			eff.hex_group_value = '0;
		end else if (is_hex) begin
			if (acc > GROUP_MAX) begin
				eff.segment_hex_ok  = 1'b0;
				eff.hex_group_value = GROUP_SAT;
			end else begin
				eff.hex_group_value = acc[16:0];
			end
		end else begin
			eff.segment_hex_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_q <= hex_clear();
		end else if (step) begin
			hex_q <= done ? hex_clear() : eff;
		end
	end

endmodule
